// ===== hw/rtl/hhm_pkg.sv =====
// Shared types and constants of the heartbeat health monitor.
package hhm_pkg;

    localparam int SVC_W = 4;
    localparam int SEQ_W = 32;
    localparam int MAX_SLOTS = 16;

    localparam logic [2:0] HL_OK         = 3'd0;
    localparam logic [2:0] HL_DEGRADED   = 3'd1;
    localparam logic [2:0] HL_UNHEALTHY  = 3'd2;
    localparam logic [2:0] HL_FAILED     = 3'd3;
    localparam logic [2:0] HL_RECOVERING = 3'd4;

    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_DEATH = 2'd1;
    localparam logic [1:0] FLT_BEAT  = 2'd2;

    localparam logic       REQ_EVAL  = 1'b0;
    localparam logic       REQ_SUPER = 1'b1;

    localparam logic [2:0] HIST_MASK      = 3'h7;
    localparam logic [1:0] MISS_LIMIT     = 2'd3;
    localparam logic [1:0] HITS_UNHEALTHY = 2'd2;

    typedef enum logic [1:0] {
        K_RANGE = 2'd0,   // slot beyond the table
        K_IDLE  = 2'd1,   // report only: inactive slot or rejected supervisor value
        K_SUPER = 2'd2,   // supervisor writes health
        K_EVAL  = 2'd3    // full evaluation
    } t_kind;

    typedef struct packed {
        logic             req_type;
        logic [SVC_W-1:0] service;
        logic             active;
        logic             process_alive;
        logic [SEQ_W-1:0] sequence_req;
        logic             period_elapsed;
        logic [2:0]       new_health;
    } t_req;

    typedef struct packed {
        logic [SVC_W-1:0] service_out;
        logic [2:0]       health;
        logic [1:0]       fault;
        logic             heartbeat_good;
        logic             service_good;
        logic             kill_request;
        logic             state_changed;
        logic             value_invalid;
    } t_rsp;

    typedef struct packed {
        t_kind            kind;
        logic [SVC_W-1:0] service;
        logic             alive;
        logic [SEQ_W-1:0] seq;
        logic             elapsed;
        logic [2:0]       new_health;
    } t_work;

    typedef struct packed {
        logic  valid;
        t_work item;
    } t_work_lnk;

endpackage

// ===== hw/rtl/hhm_stream_if.sv =====
// Valid/ready channel carrying one payload of type T.
interface hhm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hhm_front.sv =====
// Front end: classifies requests and queues them for the back end.
module hhm_front import hhm_pkg::*; #(
    parameter int NUM_SERVICES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hhm_stream_if.sink        i_req,
    output t_work_lnk         o_lnk,
    input  logic              i_pop
);

    localparam logic [8:0] NSV = 9'(NUM_SERVICES);

    t_work      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_work      cls;
    logic       push;
    logic       pop;

    always_comb begin
        cls.service    = i_req.data.service;
        cls.alive      = i_req.data.process_alive;
        cls.seq        = i_req.data.sequence_req;
        cls.elapsed    = i_req.data.period_elapsed;
        cls.new_health = i_req.data.new_health;
        if ({5'b0, i_req.data.service} >= NSV) begin
            cls.kind = K_RANGE;
        end else if (i_req.data.req_type == REQ_SUPER) begin
            // drop health codes beyond recovering
            cls.kind = (i_req.data.new_health <= HL_RECOVERING) ? K_SUPER : K_IDLE;
        end else if (i_req.data.active) begin
            cls.kind = K_EVAL;
        end else begin
            cls.kind = K_IDLE;
        end
    end

    assign i_req.ready = (r_count != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_pop && (r_count != 2'd0);
    assign o_lnk.valid = (r_count != 2'd0);
    assign o_lnk.item  = r_q[r_rd];

    always_comb begin
        n_count = r_count;
        case ({push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && pop) |=> r_count == $past(r_count))
        else $error("simultaneous push and pop changed count");
    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_count == $past(r_count) + 2'd1)
        else $error("push without pop did not grow queue");
`endif

endmodule

// ===== hw/rtl/hhm_back.sv =====
// Back end: service table update and registered result.
module hhm_back import hhm_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_work_lnk  i_lnk,
    output logic       o_pop,
    hhm_stream_if.source o_rsp
);

    logic [SEQ_W-1:0] r_last  [DEPTH];
    logic             r_trk   [DEPTH];
    logic [2:0]       r_hist  [DEPTH];
    logic [1:0]       r_run   [DEPTH];
    logic [2:0]       r_hlth  [DEPTH];
    logic [1:0]       r_flt   [DEPTH];
    logic             r_bg    [DEPTH];
    logic             r_us    [DEPTH];

    logic             r_valid;
    t_rsp             r_out;
    t_rsp             n_out;

    t_work            w;
    logic [IW-1:0]    idx;
    logic [2:0]       old_h;
    logic [2:0]       new_h;
    logic [1:0]       new_f;
    logic             new_bg;
    logic             new_us;
    logic [2:0]       new_hist;
    logic [1:0]       new_run;
    logic             new_trk;
    logic             wr_seq;
    logic             miss;
    logic [1:0]       hits;
    logic             kill;
    logic             inval;
    logic [2:0]       shifted;

    assign w     = i_lnk.item;
    assign idx   = w.service[IW-1:0];
    assign o_pop = i_lnk.valid && (!r_valid || o_rsp.ready);
    assign old_h = r_hlth[idx];

    assign miss    = (w.seq == r_last[idx]);
    assign shifted = {r_hist[idx][1:0], miss} & HIST_MASK;
    assign hits    = 2'(shifted[0]) + 2'(shifted[1]) + 2'(shifted[2]);

    always_comb begin
        new_h    = old_h;
        new_f    = r_flt[idx];
        new_bg   = r_bg[idx];
        new_us   = r_us[idx];
        new_hist = r_hist[idx];
        new_run  = r_run[idx];
        new_trk  = r_trk[idx];
        wr_seq   = 1'b0;
        kill     = 1'b0;
        inval    = 1'b0;
        case (w.kind)
            K_SUPER: begin
                new_h = w.new_health;
            end
            K_EVAL: begin
                if (!w.alive && old_h != HL_FAILED && old_h != HL_RECOVERING) begin
                    new_h  = HL_FAILED;
                    new_f  = FLT_DEATH;
                    new_bg = 1'b0;
                    new_us = 1'b0;
                end else if (!r_trk[idx]) begin
                    // first item: latch sequence only
                    wr_seq  = 1'b1;
                    new_trk = 1'b1;
                end else if (w.elapsed && old_h != HL_FAILED) begin
                    new_hist = shifted;
                    if (miss) begin
                        new_run = (r_run[idx] == MISS_LIMIT) ? MISS_LIMIT
                                                             : r_run[idx] + 2'd1;
                    end else begin
                        new_run = 2'd0;
                        wr_seq  = 1'b1;
                    end
                    if (new_run == MISS_LIMIT) begin
                        new_h  = HL_FAILED;
                        new_f  = FLT_BEAT;
                        new_bg = 1'b0;
                        new_us = 1'b0;
                        inval  = 1'b1;
                        kill   = 1'b1;
                    end else if (hits >= HITS_UNHEALTHY) begin
                        new_h  = HL_UNHEALTHY;
                        new_bg = 1'b0;
                        new_us = 1'b0;
                        inval  = 1'b1;
                    end else if (hits == 2'd1) begin
                        new_h  = HL_DEGRADED;
                        new_bg = 1'b1;
                        new_us = 1'b1;
                    end else if (old_h != HL_RECOVERING) begin
                        new_h  = HL_OK;
                        new_bg = 1'b1;
                        new_us = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out.service_out = w.service;
        if (w.kind == K_RANGE) begin
            n_out.health         = HL_OK;
            n_out.fault          = FLT_NONE;
            n_out.heartbeat_good = 1'b0;
            n_out.service_good   = 1'b0;
            n_out.kill_request   = 1'b0;
            n_out.state_changed  = 1'b0;
            n_out.value_invalid  = 1'b0;
        end else begin
            n_out.health         = new_h;
            n_out.fault          = new_f;
            n_out.heartbeat_good = new_bg;
            n_out.service_good   = new_us;
            n_out.kill_request   = kill;
            n_out.state_changed  = (new_h != old_h);
            n_out.value_invalid  = inval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int k = 0; k < DEPTH; k++) begin
                r_trk[k]  <= 1'b0;
                r_hist[k] <= 3'd0;
                r_run[k]  <= 2'd0;
                r_hlth[k] <= HL_OK;
                r_flt[k]  <= FLT_NONE;
                r_bg[k]   <= 1'b1;
                r_us[k]   <= 1'b1;
            end
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop && w.kind != K_RANGE) begin
                r_trk[idx]  <= new_trk;
                r_hist[idx] <= new_hist;
                r_run[idx]  <= new_run;
                r_hlth[idx] <= new_h;
                r_flt[idx]  <= new_f;
                r_bg[idx]   <= new_bg;
                r_us[idx]   <= new_us;
            end
        end
    end

    // sequence is always latched before first compare, so it needs no reset
    always_ff @(posedge i_clk) begin
        if (o_pop && w.kind != K_RANGE && wr_seq) begin
            r_last[idx] <= w.seq;
        end
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.data  = r_out;

`ifndef NO_ASSERTIONS
    a_kill_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.kill_request) |-> (r_out.health == HL_FAILED &&
                                              r_out.fault == FLT_BEAT))
        else $error("kill request without heartbeat failure");
    a_inval_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.value_invalid) |-> (!r_out.service_good &&
                                               !r_out.heartbeat_good))
        else $error("invalid value with good flags");
    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped request produced no result");
`endif

endmodule

// ===== hw/rtl/heartbeat_health_monitor.sv =====
// Top level of the per-service heartbeat health monitor.
//
//  channel | dir | payload | accepted when
//  i_req   | in  | t_req   | i_req.valid && i_req.ready
//  o_rsp   | out | t_rsp   | o_rsp.valid && o_rsp.ready
//
// Sustains one request per cycle while the output is not stalled, set by the read-modify-write of the
// service table in the back end. After its request is taken, a result passes through the two-entry
// queue and then the output register, where it becomes valid.
// Reset clears the table at once; there is no clearing pass.
// A stalled output holds the back end; the queue keeps taking requests until full.
module heartbeat_health_monitor import hhm_pkg::*; #(
    parameter int NUM_SERVICES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hhm_stream_if.sink    i_req,
    hhm_stream_if.source  o_rsp
);

    // slots beyond the 4-bit index are unreachable
    localparam int DEPTH = (NUM_SERVICES < MAX_SLOTS) ? NUM_SERVICES : MAX_SLOTS;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_work_lnk lnk;
    logic      pop;

    hhm_front #(
        .NUM_SERVICES (NUM_SERVICES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_lnk   (lnk),
        .i_pop   (pop)
    );

    hhm_back #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lnk   (lnk),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
